[hw/rtl/lssm_pkg.sv]
// Shared widths and the control type of the LRU sample slot manager.
`default_nettype none

package lssm_pkg;

   localparam int IDX_W   = 6;
   localparam int LEN_W   = 13;
   localparam int PRI_W   = 16;
   localparam int SLOT_W  = 2;
   localparam int STAMP_W = 16;

   // Control from the sequencer to the LRU scan unit.
   typedef struct packed {
      logic start;    // clear the accumulators before a new scan
      logic strobe;   // memory read data of one entry is present
      logic hit;      // that entry holds a resident sample
   } scan_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/lssm_if.sv]
// Valid/ready channel interfaces for play requests and their results.
`default_nettype none

interface lssm_req_if;
   import lssm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        sample_index;
   logic [LEN_W-1:0]        sample_length;
   logic signed [PRI_W-1:0] priority_req;
   logic                    player_busy;

   modport source (output valid, output sample_index, output sample_length,
                   output priority_req, output player_busy, input ready);
   modport sink   (input valid, input sample_index, input sample_length,
                   input priority_req, input player_busy, output ready);
endinterface

interface lssm_rsp_if;
   import lssm_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic              played;
   logic [SLOT_W-1:0] slot;
   logic              load_needed;
   logic              evict_valid;
   logic [IDX_W-1:0]  evicted_sample;

   modport source (output valid, output accepted, output played, output slot,
                   output load_needed, output evict_valid, output evicted_sample,
                   input ready);
   modport sink   (input valid, input accepted, input played, input slot,
                   input load_needed, input evict_valid, input evicted_sample,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/lssm_state_mem.sv]
// Per-sample memory of buffer slot and use stamp, one read and one write port.
`default_nettype none

module lssm_state_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 18
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/lssm_lru_scan.sv]
// Scan unit that counts resident samples and tracks the least recently used one.
`default_nettype none

module lssm_lru_scan #(
   parameter int AW = 6,
   parameter int CW = 7,
   parameter int SW = 2
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lssm_pkg::scan_ctl_type       scan_ctl,
   input  wire logic [AW-1:0]                entry_addr,
   input  wire logic [lssm_pkg::STAMP_W-1:0] entry_stamp,
   input  wire logic [SW-1:0]                entry_slot,
   output logic      [CW-1:0]                count,
   output logic                              have,
   output logic      [AW-1:0]                victim,
   output logic      [SW-1:0]                victim_slot
);
   import lssm_pkg::*;

   logic [CW-1:0]      count_ff, count_in;
   logic               have_ff, have_in;
   logic [STAMP_W-1:0] best_ff, best_in;
   logic [AW-1:0]      victim_ff, victim_in;
   logic [SW-1:0]      vslot_ff, vslot_in;

   always_comb begin
      count_in  = count_ff;
      have_in   = have_ff;
      best_in   = best_ff;
      victim_in = victim_ff;
      vslot_in  = vslot_ff;
      if (scan_ctl.start) begin
         count_in = '0;
         have_in  = 1'b0;
      end else if (scan_ctl.strobe && scan_ctl.hit) begin
         count_in = count_ff + 1'b1;
         // Strict less-than keeps the lowest-numbered entry on equal stamps.
         if (!have_ff || (entry_stamp < best_ff)) begin
            have_in   = 1'b1;
            best_in   = entry_stamp;
            victim_in = entry_addr;
            vslot_in  = entry_slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         have_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         have_ff  <= have_in;
      end
      best_ff   <= best_in;
      victim_ff <= victim_in;
      vslot_ff  <= vslot_in;
   end

   assign count       = count_ff;
   assign have        = have_ff;
   assign victim      = victim_ff;
   assign victim_slot = vslot_ff;

endmodule

`default_nettype wire

[hw/rtl/lru_sample_slot_manager_top.sv]
// Top level of the LRU sample slot manager: sequencer, residency bits and result register.
//
// Usage: play requests arrive as transactions on req_chan (sample number, stored
// length, priority, player busy flag). Each request yields exactly one result
// transaction on rsp_chan: acceptance, whether the sample plays, its buffer slot,
// whether it must be loaded now and which sample, if any, was evicted.
// csr_wr_en with csr_wr_data writes the enable bit; write it only while idle.
// A rejected request or a zero-length miss goes from acceptance straight to ST_DONE,
// and a resident hit passes through ST_PLAY first. A miss that needs a slot walks
// the whole per-sample memory once in ST_SCAN, one entry per cycle through its single
// read port, and then allocates in ST_ALLOC.
// The block takes one request at a time: req_chan.ready is high only when the
// sequencer is idle, so a request waits until the previous one has left ST_DONE.
// The result sits in an output register, so a new request is taken while the
// previous result still waits for rsp_chan.ready; a stalled receiver holds the
// block only when a second result is ready to be written.
// Reset clears all residency bits, the use counter and the last priority, and
// sets enable to one. The slot/stamp memory needs no clearing: an entry's data is used
// only after it has been written.
`default_nettype none

module lru_sample_slot_manager_top #(
   parameter int NUM_SAMPLES = 64,
   parameter int SLOTS       = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   lssm_req_if.sink   req_chan,
   lssm_rsp_if.source rsp_chan,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);
   import lssm_pkg::*;

   localparam int AW = $clog2(NUM_SAMPLES);
   localparam int CW = $clog2(NUM_SAMPLES + 1);
   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DW = SW + STAMP_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_ALLOC = 5'b00100,
      ST_PLAY  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic                    enable_ff, enable_in;
   logic signed [PRI_W-1:0] last_pri_ff, last_pri_in;
   logic [STAMP_W-1:0]      use_cnt_ff, use_cnt_in;
   logic [NUM_SAMPLES-1:0]  valid_ff, valid_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           scan_cnt_ff, scan_cnt_in;
   logic                    strobe_ff, strobe_in;
   logic [AW-1:0]           strobe_addr_ff, strobe_addr_in;

   // Result staged by the sequencer, then moved into the output register.
   logic              res_acc_ff, res_acc_in;
   logic              res_play_ff, res_play_in;
   logic [SW-1:0]     res_slot_ff, res_slot_in;
   logic              res_load_ff, res_load_in;
   logic              res_ev_ff, res_ev_in;
   logic [IDX_W-1:0]  res_evs_ff, res_evs_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_acc_ff, rsp_acc_in;
   logic              rsp_play_ff, rsp_play_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_load_ff, rsp_load_in;
   logic              rsp_ev_ff, rsp_ev_in;
   logic [IDX_W-1:0]  rsp_evs_ff, rsp_evs_in;

   // Memory and scan unit connections.
   logic [AW-1:0]      mem_rd_addr;
   logic [DW-1:0]      mem_rd_data;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic [DW-1:0]      mem_wr_data;
   scan_ctl_type       scan_ctl;
   logic [CW-1:0]      scan_count;
   logic               scan_have;
   logic [AW-1:0]      scan_victim;
   logic [SW-1:0]      scan_vslot;

   logic               req_fire;
   logic [AW-1:0]      req_addr;
   logic               req_ok;
   logic               slots_full;
   logic [SW-1:0]      alloc_slot;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign req_addr = AW'(req_chan.sample_index);

   // Enable, index range and priority test; a busy player needs at least the last priority.
   assign req_ok = enable_ff
                   && (32'(req_chan.sample_index) < NUM_SAMPLES)
                   && (!req_chan.player_busy || (req_chan.priority_req >= last_pri_ff));

   assign slots_full = (32'(scan_count) >= SLOTS) && scan_have;
   assign alloc_slot = slots_full ? scan_vslot : SW'(scan_count);

   // The memory read address follows the sequencer: the request index while idle,
   // the sweep counter while scanning.
   always_comb begin
      case (state_ff)
         ST_IDLE: mem_rd_addr = req_addr;
         ST_SCAN: mem_rd_addr = scan_cnt_ff[AW-1:0];
         default: mem_rd_addr = idx_ff;
      endcase
   end

   assign scan_ctl.start  = req_fire;
   assign scan_ctl.strobe = strobe_ff;
   assign scan_ctl.hit    = valid_ff[strobe_addr_ff];

   always_comb begin
      state_in       = state_ff;
      enable_in      = csr_wr_en ? csr_wr_data : enable_ff;
      last_pri_in    = last_pri_ff;
      use_cnt_in     = use_cnt_ff;
      valid_in       = valid_ff;
      idx_in         = idx_ff;
      scan_cnt_in    = scan_cnt_ff;
      strobe_in      = 1'b0;
      strobe_addr_in = scan_cnt_ff[AW-1:0];
      res_acc_in     = res_acc_ff;
      res_play_in    = res_play_ff;
      res_slot_in    = res_slot_ff;
      res_load_in    = res_load_ff;
      res_ev_in      = res_ev_ff;
      res_evs_in     = res_evs_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = idx_ff;
      mem_wr_data    = {mem_rd_data[DW-1:STAMP_W], use_cnt_ff};

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_play_in  = rsp_play_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_evs_in   = rsp_evs_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in      = req_addr;
               res_acc_in  = req_ok;
               res_play_in = 1'b0;
               res_slot_in = '0;
               res_load_in = 1'b0;
               res_ev_in   = 1'b0;
               res_evs_in  = '0;
               state_in    = ST_DONE;
               if (req_ok) begin
                  last_pri_in = req_chan.priority_req;
                  if (valid_ff[req_addr]) begin
                     state_in = ST_PLAY;
                  end else if (req_chan.sample_length != '0) begin
                     scan_cnt_in = '0;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (32'(scan_cnt_ff) < NUM_SAMPLES) begin
               strobe_in   = 1'b1;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end else begin
               // The last entry's data reaches the scan unit at this edge.
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            if (slots_full) begin
               valid_in[scan_victim] = 1'b0;
               res_ev_in             = 1'b1;
               res_evs_in            = IDX_W'(scan_victim);
            end
            valid_in[idx_ff] = 1'b1;
            mem_wr_en        = 1'b1;
            mem_wr_data      = {alloc_slot, use_cnt_ff};
            use_cnt_in       = use_cnt_ff + 1'b1;
            res_play_in      = 1'b1;
            res_slot_in      = alloc_slot;
            res_load_in      = 1'b1;
            state_in         = ST_DONE;
         end
         ST_PLAY: begin
            // Resident hit: keep the stored slot, refresh the stamp.
            mem_wr_en   = 1'b1;
            use_cnt_in  = use_cnt_ff + 1'b1;
            res_play_in = 1'b1;
            res_slot_in = mem_rd_data[DW-1:STAMP_W];
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_play_in  = res_play_ff;
               rsp_slot_in  = SLOT_W'(res_slot_ff);
               rsp_load_in  = res_load_ff;
               rsp_ev_in    = res_ev_ff;
               rsp_evs_in   = res_evs_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b1;
         last_pri_ff  <= '0;
         use_cnt_ff   <= '0;
         valid_ff     <= '0;
         strobe_ff    <= 1'b0;
         scan_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         last_pri_ff  <= last_pri_in;
         use_cnt_ff   <= use_cnt_in;
         valid_ff     <= valid_in;
         strobe_ff    <= strobe_in;
         scan_cnt_ff  <= scan_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      strobe_addr_ff <= strobe_addr_in;
      res_acc_ff     <= res_acc_in;
      res_play_ff    <= res_play_in;
      res_slot_ff    <= res_slot_in;
      res_load_ff    <= res_load_in;
      res_ev_ff      <= res_ev_in;
      res_evs_ff     <= res_evs_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_play_ff    <= rsp_play_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_load_ff    <= rsp_load_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_evs_ff     <= rsp_evs_in;
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.accepted       = rsp_acc_ff;
   assign rsp_chan.played         = rsp_play_ff;
   assign rsp_chan.slot           = rsp_slot_ff;
   assign rsp_chan.load_needed    = rsp_load_ff;
   assign rsp_chan.evict_valid    = rsp_ev_ff;
   assign rsp_chan.evicted_sample = rsp_evs_ff;

   lssm_state_mem #(
      .DEPTH (NUM_SAMPLES),
      .AW    (AW),
      .DW    (DW)
   ) u_state_mem (
      .clock   (clock),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   lssm_lru_scan #(
      .AW (AW),
      .CW (CW),
      .SW (SW)
   ) u_lru_scan (
      .clock       (clock),
      .reset       (reset),
      .scan_ctl    (scan_ctl),
      .entry_addr  (strobe_addr_ff),
      .entry_stamp (mem_rd_data[STAMP_W-1:0]),
      .entry_slot  (mem_rd_data[DW-1:STAMP_W]),
      .count       (scan_count),
      .have        (scan_have),
      .victim      (scan_victim),
      .victim_slot (scan_vslot)
   );

`ifndef ASSERT_OFF
   // Never more samples resident than there are buffer slots.
   a_slot_limit: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) <= SLOTS)
      else $error("more resident samples than slots");

   // A slot is only allocated for a sample that is not yet resident.
   a_alloc_miss: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |-> !valid_ff[idx_ff])
      else $error("allocation for a resident sample");

   // After allocation the requested sample is resident.
   a_alloc_sets: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC) |=> valid_ff[$past(idx_ff)])
      else $error("allocated sample not marked resident");

   // An eviction always comes with a load, and a load with a play.
   a_result_cons: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((!rsp_ev_ff || rsp_load_ff) && (!rsp_load_ff || rsp_play_ff)))
      else $error("inconsistent result flags");
`endif

endmodule

`default_nettype wire
